@@ rtl/smv_pkg.sv @@
package smv_pkg;

	// Vector store size and derived widths.
	localparam int MAX_LENGTH = 64;
	localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int SAMPLE_W = 16;
	localparam int EXP_W = 17;
	localparam int SUM_W = EXP_W + IDX_W;
	localparam int NUM_W = EXP_W + 16;
	localparam int DIV_STEPS = NUM_W;
	localparam int DCNT_W = $clog2(DIV_STEPS + 1);

	// Exponent handling: k values of 4096 or more always give zero.
	localparam int EXP_BITS = 12;
	localparam int PIDX_W = $clog2(EXP_BITS);
	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic signed [SAMPLE_W-1:0] CLIP_RESET = 16'shC000;
	localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;

	typedef enum logic [3:0] {
		S_COLLECT,
		S_EXP_RD,
		S_EXP_K,
		S_EXP_BIT,
		S_MUL,
		S_MUL_ADD,
		S_MUL_DONE,
		S_EXP_WR,
		S_DIV_RD,
		S_DIV_LD,
		S_DIV,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             sample_we;
		logic             max_clr;
		logic             exp_load;
		logic             k_next;
		logic             mul_en;
		logic [1:0]       mul_step;
		logic             mul_clr;
		logic             mul_acc;
		logic             mul_done;
		logic             exp_wr;
		logic             sum_clr;
		logic             div_load;
		logic             div_step;
		logic             last_set;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic k_zero;
		logic k_lsb;
	} status_t;

	// Q2.62 product with truncation, used to build the power table.
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Table of b^(2^j) with b = exp(-1/256) from its Taylor series.
	function automatic logic [EXP_BITS-1:0][63:0] pow_table();
		logic [63:0] term;
		logic [63:0] s;
		logic [EXP_BITS-1:0][63:0] t;
		term = ONE_Q62;
		s = ONE_Q62;
		term = (term >> 8) / 64'd1;  s = s - term;
		term = (term >> 8) / 64'd2;  s = s + term;
		term = (term >> 8) / 64'd3;  s = s - term;
		term = (term >> 8) / 64'd4;  s = s + term;
		term = (term >> 8) / 64'd5;  s = s - term;
		term = (term >> 8) / 64'd6;  s = s + term;
		term = (term >> 8) / 64'd7;  s = s - term;
		term = (term >> 8) / 64'd8;  s = s + term;
		term = (term >> 8) / 64'd9;  s = s - term;
		term = (term >> 8) / 64'd10; s = s + term;
		t[0] = s;
		for (int j = 1; j < EXP_BITS; j++) begin
			t[j] = mul_q62(t[j-1], t[j-1]);
		end
		return t;
	endfunction

	localparam logic [EXP_BITS-1:0][63:0] POW_TAB = pow_table();

endpackage

@@ rtl/smv_if.sv @@
// Sample request channel.
interface smv_in_if;
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          sample;
	logic                        last_in;

	modport source (output valid, output sample, output last_in, input ready);
	modport sink (input valid, input sample, input last_in, output ready);
endinterface

// Probability request channel.
interface smv_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] probability;
	logic        last_out;

	modport source (output valid, output probability, output last_out, input ready);
	modport sink (input valid, input probability, input last_out, output ready);
endinterface

@@ rtl/smv_ram.sv @@
module smv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                 wdata,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/smv_ctrl.sv @@
module smv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  smv_pkg::status_t status,
	output smv_pkg::cmd_t   cmd
);
	import smv_pkg::*;

	state_t state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] lastidx_q, lastidx_d;
	logic [1:0] step_q, step_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			cnt_q <= '0;
			idx_q <= '0;
			lastidx_q <= '0;
			step_q <= '0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			lastidx_q <= lastidx_d;
			step_q <= step_d;
			dcnt_q <= dcnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		lastidx_d = lastidx_q;
		step_d = step_q;
		dcnt_d = dcnt_q;
		cmd = '0;
		cmd.addr = idx_q;
		cmd.mul_step = step_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_COLLECT: begin
				in_ready = 1'b1;
				cmd.addr = cnt_q;
				if (in_valid) begin
					cmd.sample_we = 1'b1;
					if (in_last || cnt_q == IDX_W'(MAX_LENGTH - 1)) begin
						lastidx_d = cnt_q;
						cnt_d = '0;
						idx_d = '0;
						cmd.sum_clr = 1'b1;
						state_d = S_EXP_RD;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			S_EXP_RD: begin
				state_d = S_EXP_K;
			end
			S_EXP_K: begin
				cmd.exp_load = 1'b1;
				state_d = S_EXP_BIT;
			end
			S_EXP_BIT: begin
				if (status.k_zero) begin
					state_d = S_EXP_WR;
				end else if (status.k_lsb) begin
					step_d = '0;
					state_d = S_MUL;
				end else begin
					cmd.k_next = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_clr = (step_q == 2'd0);
				cmd.mul_acc = (step_q != 2'd0);
				step_d = step_q + 1'b1;
				if (step_q == 2'd3) begin
					state_d = S_MUL_ADD;
				end
			end
			S_MUL_ADD: begin
				cmd.mul_acc = 1'b1;
				state_d = S_MUL_DONE;
			end
			S_MUL_DONE: begin
				cmd.mul_done = 1'b1;
				cmd.k_next = 1'b1;
				state_d = S_EXP_BIT;
			end
			S_EXP_WR: begin
				cmd.exp_wr = 1'b1;
				if (idx_q == lastidx_q) begin
					idx_d = '0;
					state_d = S_DIV_RD;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_EXP_RD;
				end
			end
			S_DIV_RD: begin
				state_d = S_DIV_LD;
			end
			S_DIV_LD: begin
				cmd.div_load = 1'b1;
				cmd.last_set = (idx_q == lastidx_q);
				dcnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				dcnt_d = dcnt_q + 1'b1;
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (idx_q == lastidx_q) begin
						cmd.max_clr = 1'b1;
						state_d = S_COLLECT;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = S_DIV_RD;
					end
				end
			end
			default: begin
				state_d = S_COLLECT;
			end
		endcase
	end

endmodule

@@ rtl/smv_dp.sv @@
module smv_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smv_pkg::cmd_t            cmd,
	output smv_pkg::status_t         status,
	input  logic signed [15:0]       sample,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata,
	output logic [16:0]              probability,
	output logic                     last_out
);
	import smv_pkg::*;

	logic signed [SAMPLE_W-1:0] floor_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] srd;
	logic [EXP_W-1:0] erd;
	logic [EXP_W-1:0] e_val;
	logic [SUM_W-1:0] sum_q;
	logic [EXP_BITS-1:0] k_q;
	logic k_zero_q;
	logic [PIDX_W-1:0] pidx_q;
	logic [63:0] acc_q;
	logic [63:0] prod_s1;
	logic [1:0] sh_s1;
	logic [127:0] prod_q;
	logic [127:0] prod_add;
	logic [31:0] mx, my;
	logic [63:0] base;
	logic [64:0] rnd;
	logic [NUM_W-1:0] num_q;
	logic [SUM_W:0] rem_q;
	logic [SUM_W:0] rem_sh;
	logic last_q;
	logic signed [SAMPLE_W:0] diff, flo, dcl, kneg;

	// Sample and exp stores.
	smv_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_sram (
		.clk(clk), .we(cmd.sample_we), .addr(cmd.addr),
		.wdata(sample), .rdata(srd)
	);
	smv_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LENGTH)) u_eram (
		.clk(clk), .we(cmd.exp_wr), .addr(cmd.addr),
		.wdata(e_val), .rdata(erd)
	);

	// Clip floor register, running maximum and exp sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= CLIP_RESET;
			max_q <= MAX_RESET;
			sum_q <= '0;
		end else begin
			if (cfg_we) begin
				floor_q <= cfg_wdata;
			end
			if (cmd.max_clr) begin
				max_q <= MAX_RESET;
			end else if (cmd.sample_we && sample > max_q) begin
				max_q <= sample;
			end
			if (cmd.sum_clr) begin
				sum_q <= '0;
			end else if (cmd.exp_wr) begin
				sum_q <= sum_q + SUM_W'(e_val);
			end
		end
	end

	// Clipped negated difference to the maximum.
	always_comb begin
		diff = (SAMPLE_W+1)'(signed'(srd)) - (SAMPLE_W+1)'(max_q);
		flo = (floor_q > 0) ? '0 : (SAMPLE_W+1)'(floor_q);
		dcl = (diff < flo) ? flo : diff;
		kneg = -dcl;
	end

	// Multiplier operands for the current partial product, and the rounded exp value.
	always_comb begin
		base = POW_TAB[pidx_q];
		mx = cmd.mul_step[1] ? acc_q[63:32] : acc_q[31:0];
		my = cmd.mul_step[0] ? base[63:32] : base[31:0];
		unique case (sh_s1)
			2'd0: prod_add = {64'd0, prod_s1};
			2'd1: prod_add = {32'd0, prod_s1, 32'd0};
			default: prod_add = {prod_s1, 64'd0};
		endcase
		rnd = {1'b0, acc_q} + 65'(64'h0000_2000_0000_0000);
		e_val = k_zero_q ? '0 : rnd[62:46];
	end

	// Exponent by powers of the base, one partial product per cycle while the multiply is enabled.
	always_ff @(posedge clk) begin
		if (cmd.exp_load) begin
			acc_q <= ONE_Q62;
			pidx_q <= '0;
			k_zero_q <= |kneg[SAMPLE_W:EXP_BITS];
			k_q <= kneg[EXP_BITS-1:0];
		end else begin
			if (cmd.mul_done) begin
				acc_q <= prod_q[125:62];
			end
			if (cmd.k_next) begin
				k_q <= k_q >> 1;
				pidx_q <= pidx_q + 1'b1;
			end
		end
		if (cmd.mul_en) begin
			prod_s1 <= {32'd0, mx} * {32'd0, my};
			sh_s1 <= {1'b0, cmd.mul_step[1]} + {1'b0, cmd.mul_step[0]};
		end
		if (cmd.mul_clr) begin
			prod_q <= '0;
		end else if (cmd.mul_acc) begin
			prod_q <= prod_q + prod_add;
		end
	end

	assign status.k_zero = k_zero_q || (k_q == '0);
	assign status.k_lsb = k_q[0];

	// Restoring division, one quotient bit per cycle.
	assign rem_sh = {rem_q[SUM_W-1:0], num_q[NUM_W-1]};
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= {erd, 16'd0};
			rem_q <= '0;
			last_q <= cmd.last_set;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, sum_q}) begin
				rem_q <= rem_sh - {1'b0, sum_q};
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign probability = num_q[16:0];
	assign last_out = last_q;

endmodule

@@ rtl/softmax_vector.sv @@
// Each sample is stored when it is accepted. After the closing sample each element
// is multiplied by the table power for each set bit of its 12-bit exponent, then
// each result goes through the bit-serial division and its output request handshake.
// Throughput is set by the shared 32x32 multiplier and the bit-serial divider.
// Reset clears control, the clip floor to -64.0, the running maximum and the sum; stores are not cleared.
module softmax_vector (
	input  logic       clk,
	input  logic       arst_n,
	smv_in_if.sink     s_in,
	smv_out_if.source  p_out,
	input  logic       cfg_we,
	input  logic [15:0] cfg_wdata
);
	import smv_pkg::*;

	cmd_t cmd;
	status_t status;

	// Sequencer.
	smv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_in.valid), .in_last(s_in.last_in), .in_ready(s_in.ready),
		.out_valid(p_out.valid), .out_ready(p_out.ready),
		.status(status), .cmd(cmd)
	);

	// Arithmetic and stores.
	smv_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.sample(s_in.sample), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.probability(p_out.probability), .last_out(p_out.last_out)
	);

endmodule

@@ rtl/smv_checker.sv @@
module smv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic [16:0] out_prob
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_prob))
		else $error("result changed while stalled");

	// A probability never exceeds one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_prob <= 17'h10000)
		else $error("probability above one");

	// No sample is taken while results are pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("sample taken during output");

	// The block returns to collecting after the closing result.
	a_return: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready)
		else $error("not ready after closing result");

	// Collecting continues while no sample is offered.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("left collecting without a sample");

endmodule

bind softmax_vector smv_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(s_in.valid), .in_ready(s_in.ready),
	.out_valid(p_out.valid), .out_ready(p_out.ready),
	.out_last(p_out.last_out), .out_prob(p_out.probability)
);
